[design/kvt_pkg.sv]
// Package for the keyed value table: request and response transaction types,
// request and status codes, and the default table dimensions.
// No dependencies; used by keyed_value_table.
package kvt_pkg;

  // Default table dimensions.
  localparam int KVT_CAPACITY    = 16;
  localparam int KVT_VALUE_WIDTH = 32;

  // Request codes. Code 3 is undefined and performs no operation.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_ERASE  = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  // One request transaction.
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } kvt_req_t;

  // One response transaction.
  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] value_out;
    logic [4:0]         entry_count;
  } kvt_rsp_t;

endpackage

[design/keyed_value_table.sv]
// Keyed value table: an unsorted key/value store searched one entry per cycle.
// Depends on kvt_pkg for the transaction types, codes and default dimensions.
// A request is answered once the scan ends: the single read port compares one
// stored key per cycle, and a hit ends the scan early; a successful erase then
// passes through S_LAST and S_MOVE to move the last entry into the erased slot.
// Throughput: one request at a time. Reset clears the entry count and the
// handshake state; the key and value memories are not cleared, since only
// entries below the count are ever read.
module keyed_value_table #(
  parameter int CAPACITY    = kvt_pkg::KVT_CAPACITY,
  parameter int VALUE_WIDTH = kvt_pkg::KVT_VALUE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  kvt_pkg::kvt_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output kvt_pkg::kvt_rsp_t rsp
);
  import kvt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_LAST = 5'b00100,
    S_MOVE = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  // Entry count and scan bookkeeping.
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] iss;
  logic          dv;
  logic [AW-1:0] didx;
  logic [AW-1:0] pos;

  // Captured request.
  logic [1:0]             req_type_r;
  logic [31:0]            key_r;
  logic [VALUE_WIDTH-1:0] value_r;

  // Result held until the response register is free.
  logic [1:0]             res_status;
  logic                   res_found;
  logic [VALUE_WIDTH-1:0] res_vout;

  // Storage and its single read and write ports.
  logic [31:0]            key_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
  logic [31:0]            key_rd;
  logic [VALUE_WIDTH-1:0] val_rd;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [31:0]            wr_key;
  logic [VALUE_WIDTH-1:0] wr_val;

  logic hit, miss, scan_end, accept, rsp_free;

  assign accept   = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign hit      = dv && (key_rd == key_r);
  assign miss     = !dv && (iss >= fill);
  assign scan_end = (state == S_SCAN) && (hit || miss);

  // Sequencer, memory port control and entry count update.
  always_comb begin
    state_next = state;
    fill_next  = fill;
    wr_en      = 1'b0;
    wr_addr    = pos;
    wr_key     = key_rd;
    wr_val     = val_rd;
    rd_addr    = iss[AW-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DONE;
          if (req_type_r == REQ_INSERT && !hit && fill != CW'(CAPACITY)) begin
            wr_en     = 1'b1;
            wr_addr   = fill[AW-1:0];
            wr_key    = key_r;
            wr_val    = value_r;
            fill_next = fill + 1'b1;
          end else if (req_type_r == REQ_ERASE && hit) begin
            state_next = S_LAST;
          end
        end
      end
      S_LAST: begin
        // Read the last entry; it moves into the erased slot.
        rd_addr    = AW'(fill - 1'b1);
        fill_next  = fill - 1'b1;
        state_next = S_MOVE;
      end
      S_MOVE: begin
        wr_en      = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Key and value memories with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    key_rd <= key_mem[rd_addr];
    val_rd <= val_mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      dv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (accept) begin
        dv <= 1'b0;
      end else if (state == S_SCAN) begin
        dv <= !scan_end && (iss < fill);
      end
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request capture, scan counters and result formation.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= req.req_type;
      key_r      <= req.key;
      value_r    <= VALUE_WIDTH'($unsigned(req.value));
      iss        <= '0;
    end
    if (state == S_SCAN && !scan_end && iss < fill) begin
      didx <= iss[AW-1:0];
      iss  <= iss + 1'b1;
    end
    if (scan_end) begin
      pos        <= didx;
      res_found  <= hit;
      res_vout   <= '0;
      res_status <= STATUS_OK;
      case (req_type_r)
        REQ_INSERT: begin
          if (hit) begin
            res_status <= STATUS_DUPLICATE;
          end else if (fill == CW'(CAPACITY)) begin
            res_status <= STATUS_FULL;
          end
        end
        REQ_ERASE: begin
          if (!hit) begin
            res_status <= STATUS_NOT_FOUND;
          end
        end
        REQ_LOOKUP: begin
          if (hit) begin
            res_vout <= val_rd;
          end else begin
            res_status <= STATUS_NOT_FOUND;
          end
        end
        default: begin
          res_status <= STATUS_OK;
        end
      endcase
    end
    if (state == S_DONE && rsp_free) begin
      rsp.status      <= res_status;
      rsp.found       <= res_found;
      rsp.value_out   <= 32'(res_vout);
      rsp.entry_count <= 5'(fill);
    end
  end

  // The entry count never passes the capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // An accepted transaction starts a scan.
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_SCAN)
    else $error("accepted transaction did not start a scan");

  // Erase shrinks the table by exactly one entry before the move.
  a_erase_shrink: assert property (@(posedge clk) disable iff (rst)
    state == S_LAST |=> state == S_MOVE && fill == $past(fill) - 1'b1)
    else $error("erase did not shrink the table by one");

  // A key under comparison always comes from a filled entry.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && dv) |-> CW'(didx) < fill)
    else $error("scan compared an entry beyond the fill");

  // A response is only loaded once the scan has resolved.
  a_done_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> ($past(state) == S_SCAN || $past(state) == S_MOVE
                          || $past(state) == S_DONE))
    else $error("response stage entered out of order");

endmodule
